// ----- rtl/core/wmh_pkg.sv -----
// shared types and constants for the windowed mode filter
package wmh_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int COUNT_W    = 7;
    localparam int THRESH_W   = 12;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD  = 3'd0;
    localparam logic [THRESH_W-1:0]   THRESHOLD_RESET = 12'd5;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic                last_in_window;
    } wmh_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smoothed_value;
        logic [SAMPLE_W-1:0] raw_mode;
        logic [COUNT_W-1:0]  mode_count;
    } wmh_out_t;

    typedef struct packed {
        logic ins;
        logic shift;
    } wmh_cell_ctrl_t;

endpackage

// ----- rtl/core/wmh_cell.sv -----
// one cell of the sorted sample chain
module wmh_cell #(
    parameter int VW  = 12,
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic                    clk,
    input  wmh_pkg::wmh_cell_ctrl_t ctrl,
    input  logic [CW-1:0]           fill,
    input  logic [VW-1:0]           sample,
    input  logic [VW-1:0]           left_value,
    input  logic                    left_gt,
    input  logic [VW-1:0]           right_value,
    output logic [VW-1:0]           value,
    output logic                    gt
);
    import wmh_pkg::*;

    logic [VW-1:0] value_reg;
    logic          occupied;

    assign occupied = fill > CW'(IDX);
    // empty cells act as larger than any sample
    assign gt       = !occupied || (value_reg > sample);
    assign value    = value_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            value_reg <= right_value;
        end
        else if (ctrl.ins && gt)
        begin
            value_reg <= left_gt ? left_value : sample;
        end
    end

endmodule

// ----- rtl/core/wmh_scan.sv -----
// run-length scanner over the ascending sample stream
module wmh_scan #(
    parameter int VW = 12,
    parameter int CW = 7
) (
    input  logic          clk,
    input  logic          step,
    input  logic          first,
    input  logic [VW-1:0] head,
    output logic [VW-1:0] mode,
    output logic [CW-1:0] count
);
    import wmh_pkg::*;

    logic [VW-1:0] prev_reg;
    logic [VW-1:0] best_reg;
    logic [CW-1:0] run_reg;
    logic [CW-1:0] best_cnt_reg;
    logic          longer;

    // strict compare keeps the smallest value on a tie
    assign longer = run_reg > best_cnt_reg;
    assign mode   = longer ? prev_reg : best_reg;
    assign count  = longer ? run_reg : best_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (first)
            begin
                best_reg     <= head;
                best_cnt_reg <= CW'(1);
                run_reg      <= CW'(1);
            end
            else if (head == prev_reg)
            begin
                run_reg <= run_reg + CW'(1);
            end
            else
            begin
                if (longer)
                begin
                    best_reg     <= prev_reg;
                    best_cnt_reg <= run_reg;
                end
                run_reg <= CW'(1);
            end
            prev_reg <= head;
        end
    end

endmodule

// ----- rtl/core/window_mode_with_hysteresis.sv -----
// windowed mode filter with hysteresis, top level
// samples: one beat per cycle in the fill state, each inserted in sorted place
// while the chain has room; close beat: inserted, then the chain is shifted out
// through the run scanner, one stored sample per cycle; the result is registered
// once output is free; no input beat is taken from close until the result loads
// reset clears the fill count, held mode and state; threshold resets to 5
module window_mode_with_hysteresis #(
    parameter int MAX_WINDOW = 64,
    parameter int VALUE_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  wmh_pkg::wmh_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output wmh_pkg::wmh_out_t                out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wmh_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wmh_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wmh_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import wmh_pkg::*;

    localparam int VW = (VALUE_BITS < SAMPLE_W) ? VALUE_BITS : SAMPLE_W;
    localparam int CW = $clog2(MAX_WINDOW + 1);

    typedef enum logic [1:0] {
        ST_FILL,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t              state_reg,     state_next;
    logic [CW-1:0]       fill_reg,      fill_next;
    logic [CW-1:0]       idx_reg,       idx_next;
    logic [SAMPLE_W-1:0] held_reg,      held_next;
    logic                have_reg,      have_next;
    logic                out_valid_reg, out_valid_next;
    wmh_out_t            out_reg,       out_next;
    logic [THRESH_W-1:0] thresh_reg,    thresh_next;

    logic                in_fire;
    logic                room;
    wmh_cell_ctrl_t      cell_ctrl;
    logic [VW-1:0]       sample;
    logic [VW-1:0]       cell_value [MAX_WINDOW];
    logic                cell_gt    [MAX_WINDOW];
    logic                scan_step;
    logic                scan_first;
    logic [VW-1:0]       scan_mode;
    logic [CW-1:0]       scan_count;
    logic [SAMPLE_W+VW-1:0]   raw_ext;
    logic [SAMPLE_W-1:0]      raw_mode;
    logic [COUNT_W+CW-1:0]    cnt_ext;
    logic [SAMPLE_W-1:0]      diff;
    logic                     out_free;
    logic                     cfg_write;

    assign in_ready  = (state_reg == ST_FILL);
    assign in_fire   = in_valid && in_ready;
    assign room      = fill_reg < CW'(MAX_WINDOW);
    assign sample    = in_data.sample_value[VW-1:0];
    assign scan_step = (state_reg == ST_SCAN);
    assign scan_first = (idx_reg == '0);

    assign cell_ctrl.ins   = in_fire && room;
    assign cell_ctrl.shift = scan_step;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic [VW-1:0] left_value;
        logic          left_gt;
        logic [VW-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = '0;
            assign left_gt    = 1'b0;
        end
        else
        begin : g_mid
            assign left_value = cell_value[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        wmh_cell #(
            .VW  (VW),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .fill        (fill_reg),
            .sample      (sample),
            .left_value  (left_value),
            .left_gt     (left_gt),
            .right_value (right_value),
            .value       (cell_value[i]),
            .gt          (cell_gt[i])
        );
    end

    wmh_scan #(
        .VW (VW),
        .CW (CW)
    ) u_scan (
        .clk   (clk),
        .step  (scan_step),
        .first (scan_first),
        .head  (cell_value[0]),
        .mode  (scan_mode),
        .count (scan_count)
    );

    assign raw_ext  = {{SAMPLE_W{1'b0}}, scan_mode};
    assign raw_mode = raw_ext[SAMPLE_W-1:0];
    assign cnt_ext  = {{COUNT_W{1'b0}}, scan_count};
    assign diff     = (held_reg > raw_mode) ? (held_reg - raw_mode) : (raw_mode - held_reg);
    assign out_free = !out_valid_reg || out_ready;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_THRESHOLD) ?
                       {{(APB_DATA_W-THRESH_W){1'b0}}, thresh_reg} : '0;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        held_next      = held_reg;
        have_next      = have_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        thresh_next    = thresh_reg;

        if (cfg_write && (paddr == ADDR_THRESHOLD))
        begin
            thresh_next = pwdata[THRESH_W-1:0];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_FILL:
            begin
                if (in_fire)
                begin
                    if (room)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    if (in_data.last_in_window)
                    begin
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + CW'(1);
                if ((idx_reg + CW'(1)) == fill_reg)
                begin
                    fill_next  = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    if (!have_reg || (diff > thresh_reg))
                    begin
                        held_next = raw_mode;
                    end
                    have_next               = 1'b1;
                    out_next.smoothed_value = (!have_reg || (diff > thresh_reg)) ?
                                              raw_mode : held_reg;
                    out_next.raw_mode       = raw_mode;
                    out_next.mode_count     = cnt_ext[COUNT_W-1:0];
                    out_valid_next          = 1'b1;
                    state_next              = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_reg      <= '0;
            idx_reg       <= '0;
            held_reg      <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            thresh_reg    <= THRESHOLD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            held_reg      <= held_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            thresh_reg    <= thresh_next;
        end
    end

endmodule
